>>> rtl/mmpr_pkg.sv
// Shared constants and codes of the min/max pyramid range query block.
`default_nettype none
package mmpr_pkg;
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_HEIGHT  = 1024;
  localparam int DEF_CHUNK_SHIFT = 4;
  localparam int DEF_MAX_LEVELS  = 8;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int QUERY_BITS      = 25;
  localparam int FRAC_BITS       = 8;
  localparam int DIM_CFG_BITS    = 11;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int MAX_OVERLAP     = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_QUERY    = 1'b1;
  localparam logic KIND_TOTAL  = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;
endpackage
`default_nettype wire

>>> rtl/mmpr_if.sv
// Handshake interfaces for the request and result channels.
`default_nettype none
interface mmpr_in_if #(
  parameter int SAMPLE_BITS = mmpr_pkg::DEF_SAMPLE_BITS
);
  logic                                  valid;
  logic                                  ready;
  logic                                  op;
  logic signed [SAMPLE_BITS-1:0]         pixel_value;
  logic signed [mmpr_pkg::QUERY_BITS-1:0] query_x_min;
  logic signed [mmpr_pkg::QUERY_BITS-1:0] query_x_max;
  logic signed [mmpr_pkg::QUERY_BITS-1:0] query_y_min;
  logic signed [mmpr_pkg::QUERY_BITS-1:0] query_y_max;
  modport source (output valid, op, pixel_value, query_x_min, query_x_max,
                  query_y_min, query_y_max, input ready);
  modport sink (input valid, op, pixel_value, query_x_min, query_x_max,
                query_y_min, query_y_max, output ready);
endinterface

interface mmpr_out_if #(
  parameter int SAMPLE_BITS = mmpr_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic                          result_kind;
  logic                          valid_res;
  logic signed [SAMPLE_BITS-1:0] range_min;
  logic signed [SAMPLE_BITS-1:0] range_max;
  modport source (output valid, result_kind, valid_res, range_min, range_max,
                  input ready);
  modport sink (input valid, result_kind, valid_res, range_min, range_max,
                output ready);
endinterface
`default_nettype wire

>>> rtl/minmax_pyramid_range_query.sv
// Min/max pyramid over a streamed heightmap with wrapped range queries.
//
//   Channel | Dir | Payload                                        | Handshake
//   in_if   | in  | op, pixel_value, query_x/y_min/max              | valid/ready
//   out_if  | out | result_kind, valid_res, range_min, range_max   | valid/ready
//   cfg_*   | in  | cfg_index, cfg_wdata                            | cfg_we only
//
// A pixel load is a read and then a write of its chunk in the store.
// The last pixel starts the build: four store reads and one write per upper-level
// cell, then one read per cell of the top level, all through the single read port.
// A query runs the modulo steps and the level search, then reads each chunk that it
// visits. Reset is synchronous; the store needs no clearing.
// A finished result waits in the output register while the next item is taken.
`default_nettype none
module minmax_pyramid_range_query #(
  parameter int MAX_WIDTH   = mmpr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = mmpr_pkg::DEF_MAX_HEIGHT,
  parameter int CHUNK_SHIFT = mmpr_pkg::DEF_CHUNK_SHIFT,
  parameter int MAX_LEVELS  = mmpr_pkg::DEF_MAX_LEVELS,
  parameter int SAMPLE_BITS = mmpr_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    cfg_we,
  input  wire logic [mmpr_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [mmpr_pkg::DIM_CFG_BITS-1:0]       cfg_wdata,
  mmpr_in_if.sink                                      in_if,
  mmpr_out_if.source                                   out_if
);
  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W = $clog2(MAXD + 1);
  localparam int PL_W  = DIM_W + 1;
  localparam int CS    = CHUNK_SHIFT;
  localparam int CHUNK = 1 << CS;
  localparam int L0X   = (MAX_WIDTH + CHUNK - 1) >> CS;
  localparam int L0Y   = (MAX_HEIGHT + CHUNK - 1) >> CS;
  localparam int LXD   = (L0X > L0Y) ? L0X : L0Y;
  localparam int LX_W  = $clog2(LXD + 1);
  localparam int STORE_DEPTH = 2 * L0X * L0Y + 2 * (L0X + L0Y) + MAX_LEVELS;
  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int LC_W  = $clog2(MAX_LEVELS + 1);
  localparam int LOD_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int QW    = mmpr_pkg::QUERY_BITS;
  localparam int FB    = mmpr_pkg::FRAC_BITS;
  localparam int PW    = QW - FB + 1;
  localparam int CNT_W = 2 * LX_W;
  localparam int MC_W  = $clog2(PW + 1);
  localparam int SB    = SAMPLE_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_WR, S_B_LVL, S_B_CELL, S_W_RD, S_W_END, S_Q_PREP, S_Q_MOD,
    S_Q_FIX, S_Q_LOD, S_Q_SET, S_Q_WALK, S_Q_END, S_EMIT
  } state_t;

  state_t state_r;

  logic [2*SB-1:0] mem [STORE_DEPTH];
  logic [2*SB-1:0] rdata_r;
  logic [AW-1:0]   mem_raddr;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [2*SB-1:0] mem_wdata;

  logic [DIM_W-1:0] img_w_r, img_h_r, built_w_r, built_h_r;
  logic [DIM_W-1:0] col_r, row_r;
  logic [LC_W-1:0]  lvl_cnt_r;
  logic [LX_W-1:0]  lvl_sx [MAX_LEVELS];
  logic [LX_W-1:0]  lvl_sy [MAX_LEVELS];
  logic [AW-1:0]    lvl_off [MAX_LEVELS];

  logic                 pend_use_r, pend_first_r;
  logic signed [SB-1:0] acc_min_r, acc_max_r, acc_min_nxt, acc_max_nxt;
  logic signed [SB-1:0] rd_min, rd_max;

  logic signed [SB-1:0] ld_v_r;
  logic [AW-1:0]        ld_idx_r;
  logic                 ld_fresh_r, ld_last_r;

  logic [LC_W-1:0] n_r;
  logic [LX_W-1:0] px_r, py_r, nsx_r, nsy_r, cx_r, cy_r;
  logic [AW-1:0]   po_r, noff_r, srcrow_r, dst_r, w_addr_r;
  logic [2:0]      k_r;
  logic [CNT_W-1:0] w_cnt_r, w_i_r;

  logic signed [PW-1:0] qa_r [2];
  logic signed [PW-1:0] qb_r [2];
  logic [PW-1:0]        len_r [2];
  logic [PW-1:0]        mag_r [2];
  logic                 full_r [2];
  logic                 neg_r [2];
  logic [DIM_W-1:0]     rem_r [2];
  logic [DIM_W-1:0]     pmin_r [2];
  logic [PL_W-1:0]      pmax_r [2];
  logic [MC_W-1:0]      mcnt_r;
  logic [DIM_W-1:0]     plen_r;
  logic [LOD_W-1:0]     lod_r;
  logic [LX_W-1:0]      qsx_r, qsy_r, wx_r, wy_r, cxa_r;
  logic [AW-1:0]        qoff_r, qrow_r;
  logic [PL_W-1:0]      ncx_r, ncy_r, ix_r, iy_r;
  logic                 first_r;

  logic                 res_kind_r, res_valid_r;
  logic signed [SB-1:0] res_min_r, res_max_r;
  logic                 out_valid_r, out_kind_r, out_vres_r;
  logic signed [SB-1:0] out_min_r, out_max_r;

  logic [DIM_W-1:0] dim_d [2];
  assign dim_d[0] = built_w_r;
  assign dim_d[1] = built_h_r;

  // Load address path.
  logic             ovr, fresh_c, col_last, row_last;
  logic [DIM_W-1:0] col_e, row_e;
  logic [PL_W-1:0]  wsum, hsum;
  logic [LX_W-1:0]  sx0_c, sy0_c;
  logic [AW-1:0]    ld_idx_c;

  always_comb begin
    ovr      = (col_r >= img_w_r) || (row_r >= img_h_r);
    col_e    = ovr ? '0 : col_r;
    row_e    = ovr ? '0 : row_r;
    wsum     = {1'b0, img_w_r} + PL_W'(CHUNK - 1);
    hsum     = {1'b0, img_h_r} + PL_W'(CHUNK - 1);
    sx0_c    = LX_W'(wsum >> CS);
    sy0_c    = LX_W'(hsum >> CS);
    ld_idx_c = AW'(col_e >> CS) + AW'(row_e >> CS) * AW'(sx0_c);
    fresh_c  = (col_e[CS-1:0] == '0) && (row_e[CS-1:0] == '0);
    col_last = (PL_W'(col_e) + PL_W'(1)) >= PL_W'(img_w_r);
    row_last = (PL_W'(row_e) + PL_W'(1)) >= PL_W'(img_h_r);
  end

  // Query floor and ceil of the fixed-point ends.
  logic signed [QW:0]   ceil_x, ceil_y;
  logic signed [PW-1:0] fl_x, fl_y, ce_x, ce_y;

  always_comb begin
    ceil_x = (QW+1)'(in_if.query_x_max) + (QW+1)'(2**FB - 1);
    ceil_y = (QW+1)'(in_if.query_y_max) + (QW+1)'(2**FB - 1);
    fl_x   = PW'(in_if.query_x_min >>> FB);
    fl_y   = PW'(in_if.query_y_min >>> FB);
    ce_x   = PW'(ceil_x >>> FB);
    ce_y   = PW'(ceil_y >>> FB);
  end

  // Merge of returned store data into the accumulator.
  always_comb begin
    rd_min      = rdata_r[SB-1:0];
    rd_max      = rdata_r[2*SB-1:SB];
    acc_min_nxt = acc_min_r;
    acc_max_nxt = acc_max_r;
    if (pend_use_r) begin
      if (pend_first_r) begin
        acc_min_nxt = rd_min;
        acc_max_nxt = rd_max;
      end else begin
        acc_min_nxt = (rd_min < acc_min_r) ? rd_min : acc_min_r;
        acc_max_nxt = (rd_max > acc_max_r) ? rd_max : acc_max_r;
      end
    end
  end

  // Build child addressing.
  logic [AW-1:0] cbase, child_addr;
  logic          vx, vy, child_use;

  always_comb begin
    cbase = srcrow_r + AW'({cx_r, 1'b0});
    vx    = {cx_r, 1'b1} < {1'b0, px_r};
    vy    = {cy_r, 1'b1} < {1'b0, py_r};
    case (k_r)
      3'd0: begin
        child_addr = cbase;
        child_use  = 1'b1;
      end
      3'd1: begin
        child_addr = cbase + AW'(1);
        child_use  = vx;
      end
      3'd2: begin
        child_addr = cbase + AW'(px_r);
        child_use  = vy;
      end
      default: begin
        child_addr = cbase + AW'(px_r) + AW'(1);
        child_use  = vx && vy;
      end
    endcase
  end

  // Store port control.
  logic signed [SB-1:0] ld_mn, ld_mx;

  always_comb begin
    ld_mn = (ld_fresh_r || ld_v_r < rd_min) ? ld_v_r : rd_min;
    ld_mx = (ld_fresh_r || ld_v_r > rd_max) ? ld_v_r : rd_max;
    case (state_r)
      S_IDLE:   mem_raddr = ld_idx_c;
      S_B_CELL: mem_raddr = child_addr;
      S_W_RD:   mem_raddr = w_addr_r;
      S_Q_WALK: mem_raddr = qrow_r + AW'(wx_r);
      default:  mem_raddr = '0;
    endcase
    mem_we    = 1'b0;
    mem_waddr = ld_idx_r;
    mem_wdata = {ld_mx, ld_mn};
    if (state_r == S_LD_WR) begin
      mem_we = 1'b1;
    end else if (state_r == S_B_CELL && k_r == 3'd4) begin
      mem_we    = 1'b1;
      mem_waddr = dst_r;
      mem_wdata = {acc_max_nxt, acc_min_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // Query helper values.
  logic [DIM_W-1:0] radj [2];
  logic [DIM_W-1:0] lenv [2];
  logic [PL_W-1:0]  cxb_c, cyb_c;
  logic [LX_W-1:0]  cxa_c, cya_c;
  logic             odd_x, odd_y;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      radj[a] = (neg_r[a] && rem_r[a] != '0) ? dim_d[a] - rem_r[a] : rem_r[a];
      lenv[a] = full_r[a] ? dim_d[a] : DIM_W'(len_r[a]);
    end
    odd_x = ((built_w_r & (built_w_r - DIM_W'(1))) != '0)
            && (pmax_r[0] >= PL_W'(built_w_r));
    odd_y = ((built_h_r & (built_h_r - DIM_W'(1))) != '0)
            && (pmax_r[1] >= PL_W'(built_h_r));
    cxa_c = LX_W'(pmin_r[0] >> (CS + lod_r));
    cya_c = LX_W'(pmin_r[1] >> (CS + lod_r));
    cxb_c = PL_W'(pmax_r[0] >> (CS + lod_r)) + PL_W'(odd_x);
    cyb_c = PL_W'(pmax_r[1] >> (CS + lod_r)) + PL_W'(odd_y);
  end

  logic [DIM_W:0] remt [2];
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      remt[a] = {rem_r[a], mag_r[a][PW-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      img_w_r     <= DIM_W'(1);
      img_h_r     <= DIM_W'(1);
      built_w_r   <= DIM_W'(1);
      built_h_r   <= DIM_W'(1);
      col_r       <= '0;
      row_r       <= '0;
      lvl_cnt_r   <= '0;
      pend_use_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_min_r  <= acc_min_nxt;
      acc_max_r  <= acc_max_nxt;
      pend_use_r <= 1'b0;
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == mmpr_pkg::REG_IMAGE_WIDTH) begin
          img_w_r <= (cfg_wdata == '0) ? DIM_W'(1) :
                     (32'(cfg_wdata) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : DIM_W'(cfg_wdata);
          col_r   <= '0;
          row_r   <= '0;
        end else if (cfg_index == mmpr_pkg::REG_IMAGE_HEIGHT) begin
          img_h_r <= (cfg_wdata == '0) ? DIM_W'(1) :
                     (32'(cfg_wdata) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : DIM_W'(cfg_wdata);
          col_r   <= '0;
          row_r   <= '0;
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            if (in_if.op == mmpr_pkg::OP_LOAD) begin
              ld_v_r     <= in_if.pixel_value;
              ld_idx_r   <= ld_idx_c;
              ld_fresh_r <= fresh_c;
              ld_last_r  <= col_last && row_last;
              if (col_e == '0 && row_e == '0) begin
                lvl_cnt_r <= '0;
              end
              if (col_last) begin
                col_r <= '0;
                row_r <= row_last ? '0 : row_e + DIM_W'(1);
              end else begin
                col_r <= col_e + DIM_W'(1);
                row_r <= row_e;
              end
              state_r <= S_LD_WR;
            end else if (lvl_cnt_r == '0) begin
              res_kind_r  <= mmpr_pkg::KIND_QUERY;
              res_valid_r <= 1'b0;
              res_min_r   <= '0;
              res_max_r   <= '0;
              state_r     <= S_EMIT;
            end else begin
              qa_r[0] <= fl_x;
              qb_r[0] <= ce_x;
              qa_r[1] <= fl_y;
              qb_r[1] <= ce_y;
              state_r <= S_Q_PREP;
            end
          end
        end
        S_LD_WR: begin
          if (ld_last_r) begin
            px_r       <= sx0_c;
            py_r       <= sy0_c;
            po_r       <= '0;
            n_r        <= LC_W'(1);
            lvl_sx[0]  <= sx0_c;
            lvl_sy[0]  <= sy0_c;
            lvl_off[0] <= '0;
            state_r    <= S_B_LVL;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_B_LVL: begin
          if (32'(n_r) < MAX_LEVELS && !(px_r == LX_W'(1) && py_r == LX_W'(1))) begin
            nsx_r    <= LX_W'(({1'b0, px_r} + (LX_W+1)'(1)) >> 1);
            nsy_r    <= LX_W'(({1'b0, py_r} + (LX_W+1)'(1)) >> 1);
            noff_r   <= po_r + AW'(px_r) * AW'(py_r);
            lvl_sx[n_r[LOD_W-1:0]]  <= LX_W'(({1'b0, px_r} + (LX_W+1)'(1)) >> 1);
            lvl_sy[n_r[LOD_W-1:0]]  <= LX_W'(({1'b0, py_r} + (LX_W+1)'(1)) >> 1);
            lvl_off[n_r[LOD_W-1:0]] <= po_r + AW'(px_r) * AW'(py_r);
            dst_r    <= po_r + AW'(px_r) * AW'(py_r);
            srcrow_r <= po_r;
            cx_r     <= '0;
            cy_r     <= '0;
            k_r      <= '0;
            state_r  <= S_B_CELL;
          end else begin
            w_addr_r <= po_r;
            w_cnt_r  <= CNT_W'(px_r) * CNT_W'(py_r);
            w_i_r    <= '0;
            state_r  <= S_W_RD;
          end
        end
        S_B_CELL: begin
          if (k_r != 3'd4) begin
            pend_use_r   <= child_use;
            pend_first_r <= (k_r == 3'd0);
            k_r          <= k_r + 3'd1;
          end else begin
            k_r   <= '0;
            dst_r <= dst_r + AW'(1);
            if ((LX_W+1)'(cx_r) + (LX_W+1)'(1) < (LX_W+1)'(nsx_r)) begin
              cx_r <= cx_r + LX_W'(1);
            end else begin
              cx_r     <= '0;
              srcrow_r <= srcrow_r + AW'({px_r, 1'b0});
              if ((LX_W+1)'(cy_r) + (LX_W+1)'(1) < (LX_W+1)'(nsy_r)) begin
                cy_r <= cy_r + LX_W'(1);
              end else begin
                n_r     <= n_r + LC_W'(1);
                px_r    <= nsx_r;
                py_r    <= nsy_r;
                po_r    <= noff_r;
                state_r <= S_B_LVL;
              end
            end
          end
        end
        S_W_RD: begin
          pend_use_r   <= 1'b1;
          pend_first_r <= (w_i_r == '0);
          w_addr_r     <= w_addr_r + AW'(1);
          w_i_r        <= w_i_r + CNT_W'(1);
          if (w_i_r + CNT_W'(1) == w_cnt_r) begin
            state_r <= S_W_END;
          end
        end
        S_W_END: begin
          lvl_cnt_r   <= n_r;
          built_w_r   <= img_w_r;
          built_h_r   <= img_h_r;
          res_kind_r  <= mmpr_pkg::KIND_TOTAL;
          res_valid_r <= 1'b1;
          res_min_r   <= acc_min_nxt;
          res_max_r   <= acc_max_nxt;
          state_r     <= S_EMIT;
        end
        S_Q_PREP: begin
          for (int a = 0; a < 2; a++) begin
            logic signed [PW-1:0] lo, hi;
            logic signed [PW:0]   dif;
            lo = (qa_r[a] > qb_r[a]) ? qb_r[a] : qa_r[a];
            hi = (qa_r[a] > qb_r[a]) ? qa_r[a] : qb_r[a];
            dif = (PW+1)'(hi) - (PW+1)'(lo);
            len_r[a]  <= PW'(dif);
            full_r[a] <= PW'(dif) >= PW'(dim_d[a]);
            neg_r[a]  <= lo < 0;
            mag_r[a]  <= (lo < 0) ? PW'(-lo) : PW'(lo);
            rem_r[a]  <= '0;
          end
          mcnt_r  <= '0;
          state_r <= S_Q_MOD;
        end
        S_Q_MOD: begin
          for (int a = 0; a < 2; a++) begin
            rem_r[a] <= (remt[a] >= {1'b0, dim_d[a]}) ?
                        DIM_W'(remt[a] - {1'b0, dim_d[a]}) : DIM_W'(remt[a]);
            mag_r[a] <= mag_r[a] << 1;
          end
          mcnt_r <= mcnt_r + MC_W'(1);
          if (mcnt_r == MC_W'(PW - 1)) begin
            state_r <= S_Q_FIX;
          end
        end
        S_Q_FIX: begin
          for (int a = 0; a < 2; a++) begin
            pmin_r[a] <= full_r[a] ? '0 : radj[a];
            pmax_r[a] <= full_r[a] ? PL_W'(dim_d[a]) : PL_W'(radj[a]) + PL_W'(len_r[a]);
          end
          plen_r  <= (lenv[1] > lenv[0]) ? lenv[1] : lenv[0];
          lod_r   <= '0;
          state_r <= S_Q_LOD;
        end
        S_Q_LOD: begin
          if (32'(plen_r) > CHUNK * mmpr_pkg::MAX_OVERLAP
              && LC_W'(lod_r) + LC_W'(1) < lvl_cnt_r) begin
            lod_r  <= lod_r + LOD_W'(1);
            plen_r <= plen_r >> 1;
          end else begin
            state_r <= S_Q_SET;
          end
        end
        S_Q_SET: begin
          qsx_r   <= lvl_sx[lod_r];
          qsy_r   <= lvl_sy[lod_r];
          qoff_r  <= lvl_off[lod_r];
          qrow_r  <= lvl_off[lod_r] + AW'(cya_c) * AW'(lvl_sx[lod_r]);
          cxa_r   <= cxa_c;
          wx_r    <= cxa_c;
          wy_r    <= cya_c;
          ncx_r   <= cxb_c - PL_W'(cxa_c);
          ncy_r   <= cyb_c - PL_W'(cya_c);
          ix_r    <= '0;
          iy_r    <= '0;
          first_r <= 1'b1;
          state_r <= S_Q_WALK;
        end
        S_Q_WALK: begin
          pend_use_r   <= 1'b1;
          pend_first_r <= first_r;
          first_r      <= 1'b0;
          if (ix_r == ncx_r) begin
            ix_r <= '0;
            wx_r <= cxa_r;
            if (iy_r == ncy_r) begin
              state_r <= S_Q_END;
            end else begin
              iy_r <= iy_r + PL_W'(1);
              if (wy_r + LX_W'(1) == qsy_r) begin
                wy_r   <= '0;
                qrow_r <= qoff_r;
              end else begin
                wy_r   <= wy_r + LX_W'(1);
                qrow_r <= qrow_r + AW'(qsx_r);
              end
            end
          end else begin
            ix_r <= ix_r + PL_W'(1);
            wx_r <= (wx_r + LX_W'(1) == qsx_r) ? '0 : wx_r + LX_W'(1);
          end
        end
        S_Q_END: begin
          res_kind_r  <= mmpr_pkg::KIND_QUERY;
          res_valid_r <= 1'b1;
          res_min_r   <= acc_min_nxt;
          res_max_r   <= acc_max_nxt;
          state_r     <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= res_kind_r;
            out_vres_r  <= res_valid_r;
            out_min_r   <= res_min_r;
            out_max_r   <= res_max_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_if.ready        = (state_r == S_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.result_kind = out_kind_r;
  assign out_if.valid_res   = out_vres_r;
  assign out_if.range_min   = out_min_r;
  assign out_if.range_max   = out_max_r;

`ifndef SYNTHESIS
  a_unbuilt_query: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && in_if.op == mmpr_pkg::OP_QUERY && lvl_cnt_r == '0)
    |=> (state_r == S_EMIT && !res_valid_r))
    else $error("query before build did not answer invalid");
  a_pend_source: assert property (@(posedge clk) disable iff (!rst_n)
    pend_use_r |-> ($past(state_r) == S_B_CELL || $past(state_r) == S_W_RD
                    || $past(state_r) == S_Q_WALK))
    else $error("merge without a store read");
  a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_Q_WALK |-> (wx_r < qsx_r && wy_r < qsy_r))
    else $error("wrapped chunk index out of level");
  a_level_limit: assert property (@(posedge clk) disable iff (!rst_n)
    32'(lvl_cnt_r) <= MAX_LEVELS)
    else $error("level count above limit");
`endif
endmodule
`default_nettype wire
